// File: hdl/twr_pkg.sv
// ----------------------------------------------------------------------------
// twr_pkg: shared constants of the timestamped window resampler
// Opcodes, status codes, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package twr_pkg;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int VAL_W   = 32;
   localparam int NPTS_W  = 7;
   localparam int LANES   = 4;
   localparam int MAX_POINTS = 64;
   localparam int IDX_W   = 6;

   // Serial multiplier and divider widths
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 34;
   localparam int PROD_W  = 66;
   localparam int DIV_W   = 66;
   localparam int MAG_W   = 34;
   localparam logic [MAG_W-1:0] MAG_CAP = 34'h2_0000_0000;

   // Opcodes
   localparam logic OP_APPEND   = 1'b0;
   localparam logic OP_RESAMPLE = 1'b1;

   // Result status codes
   localparam logic [1:0] STAT_APPEND_OK = 2'd0;
   localparam logic [1:0] STAT_REJECTED  = 2'd1;
   localparam logic [1:0] STAT_POINT     = 2'd2;

   // Register indexes
   localparam logic REG_WINDOW_LENGTH = 1'b0;
   localparam logic REG_NUM_POINTS    = 1'b1;

   // Handshake of the serial arithmetic units
   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

endpackage

// File: hdl/twr_store.sv
// ----------------------------------------------------------------------------
// twr_store: sample memories
// Time memory and value memory, one write and one registered read port each.
// ----------------------------------------------------------------------------
module twr_store #(
   parameter int CAPACITY = 16,
   parameter int CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(CAPACITY)-1:0]         wr_addr,
   input  logic [twr_pkg::TIME_W-1:0]          wr_time,
   input  logic [CHANNELS*twr_pkg::VAL_W-1:0]  wr_vals,
   input  logic [$clog2(CAPACITY)-1:0]         rd_addr,
   output logic [twr_pkg::TIME_W-1:0]          rd_time,
   output logic [CHANNELS*twr_pkg::VAL_W-1:0]  rd_vals
);

   logic [twr_pkg::TIME_W-1:0]         time_mem [CAPACITY];
   logic [CHANNELS*twr_pkg::VAL_W-1:0] vals_mem [CAPACITY];

   // Write on a stored append
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
         vals_mem[wr_addr] <= wr_vals;
      end
   end

   // Registered read, data follows the address in the next cycle
   always_ff @(posedge clock) begin
      rd_time <= time_mem[rd_addr];
      rd_vals <= vals_mem[rd_addr];
   end

endmodule

// File: hdl/twr_mul.sv
// ----------------------------------------------------------------------------
// twr_mul: serial shift-add multiplier
// One multiplier bit per cycle; done pulses with the product held after.
// ----------------------------------------------------------------------------
module twr_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [twr_pkg::MUL_A_W-1:0]    mul_a,
   input  logic [twr_pkg::MUL_B_W-1:0]    mul_b,
   output logic                           done,
   output logic [twr_pkg::PROD_W-1:0]     prod
);

   localparam int CNT_W = $clog2(twr_pkg::MUL_B_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [twr_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [twr_pkg::PROD_W-1:0]    mcand_ff, mcand_in;
   logic [twr_pkg::MUL_B_W-1:0]   mplier_ff, mplier_in;

   // Add the shifted multiplicand for each set multiplier bit
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         mcand_in  = twr_pkg::PROD_W'(mul_a);
         mplier_in = mul_b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[twr_pkg::PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[twr_pkg::MUL_B_W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(twr_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// File: hdl/twr_div.sv
// ----------------------------------------------------------------------------
// twr_div: restoring divider
// One quotient bit per cycle; done pulses with the quotient held after.
// ----------------------------------------------------------------------------
module twr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [twr_pkg::DIV_W-1:0]     numer,
   input  logic [31:0]                   denom,
   output logic                          done,
   output logic [twr_pkg::DIV_W-1:0]     quot
);

   localparam int CNT_W = $clog2(twr_pkg::DIV_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [twr_pkg::DIV_W-1:0]   quot_ff, quot_in;
   logic [31:0]                 rem_ff, rem_in;
   logic [31:0]                 den_ff, den_in;
   logic [32:0]                 shifted;

   // Shift in the next numerator bit, subtract when it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quot_ff[twr_pkg::DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = 32'(shifted - {1'b0, den_ff});
            quot_in = {quot_ff[twr_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[31:0];
            quot_in = {quot_ff[twr_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(twr_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: hdl/timestamped_window_resampler.sv
// ----------------------------------------------------------------------------
// timestamped_window_resampler: sliding sample window with linear resampling
// Stores timestamped vector samples in a ring and resamples them on request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: tuser is the opcode (append or
//   resample), tdata holds the stamp and the channel values. rsp_* returns
//   one result per append and num_points (clamped to 1..64) results per
//   resample request, tlast on the final one. csr_* writes window_length
//   and num_points; the user must do so only while idle, as the block does
//   not enforce it. An append's result is registered once the output
//   register is free. A resample produces each point by a division for the
//   point offset, a memory scan for the bracket, then per channel a serial
//   multiply and a division (a copy when the bracket stamps are equal), all
//   on shared units. One item is worked at a time; a new item is taken once
//   the last result of the previous one has moved into the output register.
//   When the receiver stalls, the output register holds and the sequencer
//   waits to load the next result. Reset empties the window and restores
//   window_length 65536 and num_points 10; the memories need no clearing.
// ----------------------------------------------------------------------------
module timestamped_window_resampler #(
   parameter int CAPACITY = 16,
   parameter int CHANNELS = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [159:0]  req_tdata,   // stamp, value_a, value_b, value_c, value_d
   input  logic          req_tuser,   // opcode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // point_a, point_b, point_c, point_d
   output logic [1:0]    rsp_tuser,   // status
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [31:0]   csr_data
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int VALS_W = CHANNELS * twr_pkg::VAL_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PUT      = 4'd1;
   localparam logic [3:0] S_OFF_GO   = 4'd2;
   localparam logic [3:0] S_OFF_WAIT = 4'd3;
   localparam logic [3:0] S_ONE_RD   = 4'd4;
   localparam logic [3:0] S_ONE_CAP  = 4'd5;
   localparam logic [3:0] S_SCAN_RD  = 4'd6;
   localparam logic [3:0] S_SCAN_CMP = 4'd7;
   localparam logic [3:0] S_LO_RD    = 4'd8;
   localparam logic [3:0] S_HI_RD    = 4'd9;
   localparam logic [3:0] S_HI_CAP   = 4'd10;
   localparam logic [3:0] S_CH       = 4'd11;
   localparam logic [3:0] S_MUL_WAIT = 4'd12;
   localparam logic [3:0] S_DIV_WAIT = 4'd13;

   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] s);
      logic [CNT_W:0] cap;
      cap = (CNT_W+1)'(CAPACITY);
      if (s >= cap) begin
         wrap_slot = SLOT_W'(s - cap);
      end else begin
         wrap_slot = SLOT_W'(s);
      end
   endfunction

   logic [3:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [SLOT_W-1:0]           oldest_ff, oldest_in;
   logic [twr_pkg::TIME_W-1:0]  newest_ff, newest_in;
   logic [31:0]                 win_ff, win_in;
   logic [twr_pkg::NPTS_W-1:0]  npts_ff, npts_in;
   logic [twr_pkg::NPTS_W-1:0]  n_ff, n_in;
   logic [twr_pkg::IDX_W-1:0]   i_ff, i_in;
   logic [twr_pkg::TIME_W-1:0]  stamp_ff, stamp_in;
   logic signed [34:0]          tau_ff, tau_in;
   logic [CNT_W-1:0]            k_ff, k_in;
   logic [CNT_W-1:0]            j_ff, j_in;
   logic [1:0]                  ch_ff, ch_in;
   logic [twr_pkg::TIME_W-1:0]  tlo_ff, tlo_in, thi_ff, thi_in;
   logic [VALS_W-1:0]           vlo_ff, vlo_in, vhi_ff, vhi_in;
   logic [31:0]                 pts_ff [twr_pkg::LANES];
   logic [31:0]                 pts_in [twr_pkg::LANES];
   logic [1:0]                  status_ff, status_in;
   logic                        resamp_ff, resamp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [127:0]                rsp_data_ff, rsp_data_in;
   logic [1:0]                  rsp_user_ff, rsp_user_in;
   logic                        rsp_last_ff, rsp_last_in;

   // Store ports
   logic                        wr_en;
   logic [SLOT_W-1:0]           wr_addr;
   logic [SLOT_W-1:0]           rd_addr;
   logic [twr_pkg::TIME_W-1:0]  rd_time;
   logic [VALS_W-1:0]           rd_vals;

   // Arithmetic units
   twr_pkg::unit_ctl_type       mul_ctl, div_ctl;
   logic [twr_pkg::PROD_W-1:0]  prod;
   logic [twr_pkg::DIV_W-1:0]   div_numer, quot;
   logic [31:0]                 div_denom;

   // Per-channel blend terms
   logic                        accept, reject, put_ok, is_last;
   logic [twr_pkg::TIME_W-1:0]  stamp_req;
   logic [31:0]                 vlo_c, vhi_c, dt, ad;
   logic signed [32:0]          diff;
   logic signed [35:0]          dtau;
   logic [33:0]                 at;
   logic                        neg;
   logic [twr_pkg::MAG_W-1:0]   mag;
   logic signed [34:0]          sum;
   logic [31:0]                 blended;
   logic [twr_pkg::NPTS_W-1:0]  n_eff;

   assign accept    = req_tvalid && req_tready;
   assign stamp_req = req_tdata[31:0];
   assign reject    = (count_ff != '0) && (stamp_req < newest_ff);
   assign put_ok    = !rsp_valid_ff || rsp_tready;
   assign is_last   = ({1'b0, i_ff} == (n_ff - 1'b1));

   // Clamp the requested point count to 1..64
   always_comb begin
      if (npts_ff == '0) begin
         n_eff = twr_pkg::NPTS_W'(1);
      end else if (npts_ff > twr_pkg::NPTS_W'(twr_pkg::MAX_POINTS)) begin
         n_eff = twr_pkg::NPTS_W'(twr_pkg::MAX_POINTS);
      end else begin
         n_eff = npts_ff;
      end
   end

   // Blend terms for the current channel
   always_comb begin
      vlo_c = vlo_ff[int'(ch_ff)*twr_pkg::VAL_W +: twr_pkg::VAL_W];
      vhi_c = vhi_ff[int'(ch_ff)*twr_pkg::VAL_W +: twr_pkg::VAL_W];
      dt    = thi_ff - tlo_ff;
      diff  = $signed({vhi_c[31], vhi_c}) - $signed({vlo_c[31], vlo_c});
      ad    = diff[32] ? 32'(-diff) : diff[31:0];
      dtau  = 36'(tau_ff) - $signed({4'b0000, tlo_ff});
      at    = dtau[35] ? 34'(-dtau) : dtau[33:0];
      neg   = diff[32] != dtau[35];
      mag   = (quot > twr_pkg::DIV_W'(twr_pkg::MAG_CAP)) ? twr_pkg::MAG_CAP
                                                         : quot[twr_pkg::MAG_W-1:0];
      if (neg) begin
         sum = $signed({{3{vlo_c[31]}}, vlo_c}) - $signed({1'b0, mag});
      end else begin
         sum = $signed({{3{vlo_c[31]}}, vlo_c}) + $signed({1'b0, mag});
      end
      // Saturate to the signed 32-bit range
      if (sum > 35'sh0_7FFF_FFFF) begin
         blended = 32'h7FFF_FFFF;
      end else if (sum < -35'sh0_8000_0000) begin
         blended = 32'h8000_0000;
      end else begin
         blended = sum[31:0];
      end
   end

   // Write slot of an accepted append
   assign wr_en   = accept && (req_tuser == twr_pkg::OP_APPEND) && !reject;
   assign wr_addr = (count_ff == CNT_W'(CAPACITY)) ? oldest_ff
                  : wrap_slot((CNT_W+1)'(oldest_ff) + (CNT_W+1)'(count_ff));

   // Read address by state
   always_comb begin
      case (state_ff)
         S_SCAN_RD: rd_addr = wrap_slot((CNT_W+1)'(oldest_ff) + (CNT_W+1)'(k_ff));
         S_LO_RD:   rd_addr = wrap_slot((CNT_W+1)'(oldest_ff) + (CNT_W+1)'(j_ff));
         S_HI_RD:   rd_addr = wrap_slot((CNT_W+1)'(oldest_ff) + (CNT_W+1)'(j_ff) + 1'b1);
         default:   rd_addr = oldest_ff;
      endcase
   end

   // Unit starts; divider shared by the offset and the blend quotient
   always_comb begin
      mul_ctl.start = (state_ff == S_CH) && (dt != '0);
      div_ctl.start = (state_ff == S_OFF_GO) || ((state_ff == S_MUL_WAIT) && mul_ctl.done);
      if (state_ff == S_OFF_GO) begin
         div_numer = twr_pkg::DIV_W'({32'b0, i_ff} * {6'b0, win_ff});
         div_denom = 32'(n_ff);
      end else begin
         div_numer = prod;
         div_denom = dt;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      win_in       = win_ff;
      npts_in      = npts_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      stamp_in     = stamp_ff;
      tau_in       = tau_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      ch_in        = ch_ff;
      tlo_in       = tlo_ff;
      thi_in       = thi_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      pts_in       = pts_ff;
      status_in    = status_ff;
      resamp_in    = resamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      // Configuration writes
      if (csr_valid) begin
         case (csr_index)
            twr_pkg::REG_WINDOW_LENGTH: win_in  = csr_data;
            twr_pkg::REG_NUM_POINTS:    npts_in = csr_data[twr_pkg::NPTS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               for (int c = 0; c < twr_pkg::LANES; c++) begin
                  pts_in[c] = '0;
               end
               if (req_tuser == twr_pkg::OP_APPEND) begin
                  resamp_in = 1'b0;
                  state_in  = S_PUT;
                  if (reject) begin
                     status_in = twr_pkg::STAT_REJECTED;
                  end else begin
                     status_in = twr_pkg::STAT_APPEND_OK;
                     newest_in = stamp_req;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        oldest_in = wrap_slot((CNT_W+1)'(oldest_ff) + 1'b1);
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end else begin
                  resamp_in = 1'b1;
                  status_in = twr_pkg::STAT_POINT;
                  stamp_in  = stamp_req;
                  n_in      = n_eff;
                  i_in      = '0;
                  state_in  = S_OFF_GO;
               end
            end
         end
         S_OFF_GO: begin
            state_in = S_OFF_WAIT;
         end
         S_OFF_WAIT: begin
            if (div_ctl.done) begin
               tau_in = $signed({3'b000, stamp_ff}) - $signed({3'b000, win_ff})
                      + $signed({3'b000, quot[31:0]});
               for (int c = 0; c < twr_pkg::LANES; c++) begin
                  pts_in[c] = '0;
               end
               k_in = CNT_W'(1);
               j_in = '0;
               if (count_ff == '0) begin
                  state_in = S_PUT;
               end else if (count_ff == CNT_W'(1)) begin
                  state_in = S_ONE_RD;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_ONE_RD: begin
            state_in = S_ONE_CAP;
         end
         S_ONE_CAP: begin
            // Repeat the only stored sample
            for (int c = 0; c < twr_pkg::LANES; c++) begin
               if (c < CHANNELS) begin
                  pts_in[c] = rd_vals[c*twr_pkg::VAL_W +: twr_pkg::VAL_W];
               end
            end
            state_in = S_PUT;
         end
         S_SCAN_RD: begin
            if ((k_ff + 1'b1) < count_ff) begin
               state_in = S_SCAN_CMP;
            end else begin
               state_in = S_LO_RD;
            end
         end
         S_SCAN_CMP: begin
            // Times are in order: stop at the first one past tau
            if ($signed({4'b0000, rd_time}) <= 36'(tau_ff)) begin
               j_in     = k_ff;
               k_in     = k_ff + 1'b1;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_LO_RD;
            end
         end
         S_LO_RD: begin
            state_in = S_HI_RD;
         end
         S_HI_RD: begin
            tlo_in   = rd_time;
            vlo_in   = rd_vals;
            state_in = S_HI_CAP;
         end
         S_HI_CAP: begin
            thi_in   = rd_time;
            vhi_in   = rd_vals;
            ch_in    = '0;
            state_in = S_CH;
         end
         S_CH: begin
            if (dt == '0) begin
               pts_in[ch_ff] = vhi_c;
               ch_in = ch_ff + 1'b1;
               if (ch_ff == 2'(CHANNELS - 1)) begin
                  state_in = S_PUT;
               end
            end else begin
               state_in = S_MUL_WAIT;
            end
         end
         S_MUL_WAIT: begin
            if (mul_ctl.done) begin
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_ctl.done) begin
               pts_in[ch_ff] = blended;
               ch_in = ch_ff + 1'b1;
               if (ch_ff == 2'(CHANNELS - 1)) begin
                  state_in = S_PUT;
               end else begin
                  state_in = S_CH;
               end
            end
         end
         S_PUT: begin
            // Load the output register once it is free
            if (put_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pts_ff[3], pts_ff[2], pts_ff[1], pts_ff[0]};
               rsp_user_in  = status_ff;
               rsp_last_in  = !resamp_ff || is_last;
               if (resamp_ff && !is_last) begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_OFF_GO;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         win_ff       <= 32'd65536;
         npts_ff      <= twr_pkg::NPTS_W'(10);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         win_ff       <= win_in;
         npts_ff      <= npts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      newest_ff   <= newest_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      stamp_ff    <= stamp_in;
      tau_ff      <= tau_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      ch_ff       <= ch_in;
      tlo_ff      <= tlo_in;
      thi_ff      <= thi_in;
      vlo_ff      <= vlo_in;
      vhi_ff      <= vhi_in;
      pts_ff      <= pts_in;
      status_ff   <= status_in;
      resamp_ff   <= resamp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   twr_store #(
      .CAPACITY (CAPACITY),
      .CHANNELS (CHANNELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_time (stamp_req),
      .wr_vals (req_tdata[32 +: VALS_W]),
      .rd_addr (rd_addr),
      .rd_time (rd_time),
      .rd_vals (rd_vals)
   );

   twr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_ctl.start),
      .mul_a (ad),
      .mul_b (at),
      .done  (mul_ctl.done),
      .prod  (prod)
   );

   twr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_ctl.start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_ctl.done),
      .quot  (quot)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

   // Window bookkeeping stays in range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count above capacity");

   // The ring start moves only once the window is full
   a_oldest_full: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff != '0) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("oldest slot moved before the window filled");

   // Append results are single and carry tlast
   a_append_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != twr_pkg::STAT_POINT)) |-> rsp_tlast)
      else $error("append result without tlast");

   // A rejected append leaves the window unchanged
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == twr_pkg::OP_APPEND) && reject)
      |=> ($stable(count_ff) && $stable(oldest_ff)))
      else $error("rejected append changed the window");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the timestamped window resampler
// Drives appends and resample requests through the request stream and writes
// both registers over several phases of sender and receiver idling. A
// scoreboard keeps its own copy of the sample ring, predicts every result and
// checks the response stream field by field.
// ----------------------------------------------------------------------------

typedef struct {
   logic [1:0]         status;
   logic signed [31:0] point [4];
   logic               last;
} point_result_type;

class resample_scoreboard;
   bit [31:0]          ring_time [16];
   logic signed [31:0] ring_val [16][4];
   int unsigned        head_slot;
   int unsigned        fill;
   bit [31:0]          horizon;
   bit [6:0]           points_cfg;
   point_result_type   pending [$];
   int                 errors;

   function new();
      head_slot  = 0;
      fill       = 0;
      horizon    = 32'h0001_0000;
      points_cfg = 7'd10;
      errors     = 0;
   endfunction

   task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function void write_reg(logic idx, bit [31:0] data);
      if (idx == twr_pkg::REG_WINDOW_LENGTH) horizon = data;
      else points_cfg = data[6:0];
   endfunction

   function longint stamp_at(int unsigned k);
      return longint'(ring_time[(head_slot + k) % 16]);
   endfunction

   function longint value_at(int unsigned k, int ch);
      return longint'(ring_val[(head_slot + k) % 16][ch]);
   endfunction

   // Interpolate or extrapolate one channel, truncating toward zero, saturated
   function longint blend(longint vlo, longint vhi, longint tlo, longint thi,
                          longint tau);
      longint dt, diff, dtau, res;
      longint unsigned ad, at, q, r, mag, udt, cap;
      bit neg;
      cap = longint'(twr_pkg::MAG_CAP);
      dt = thi - tlo;
      if (dt <= 0) return vhi;
      diff = vhi - vlo;
      dtau = tau - tlo;
      ad = (diff < 0) ? -diff : diff;
      at = (dtau < 0) ? -dtau : dtau;
      neg = (diff < 0) != (dtau < 0);
      udt = dt;
      q = at / udt;
      r = at % udt;
      if (ad != 0 && q > cap / ad) mag = cap;
      else begin
         mag = ad * q + (ad * r) / udt;
         if (mag > cap) mag = cap;
      end
      res = neg ? vlo - longint'(mag) : vlo + longint'(mag);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return res;
   endfunction

   // Update the ring and queue the results caused by one request transfer
   function void note_request(logic op, bit [31:0] stamp, logic signed [31:0] v [4]);
      point_result_type res;
      int unsigned n, j, slot;
      longint unsigned off;
      longint tau;
      for (int c = 0; c < 4; c++) res.point[c] = 0;
      res.last = 1'b1;
      if (op == twr_pkg::OP_APPEND) begin
         if (fill > 0 && longint'(stamp) < stamp_at(fill - 1)) begin
            res.status = twr_pkg::STAT_REJECTED;
         end else begin
            if (fill >= 16) begin
               slot = head_slot;
               head_slot = (head_slot + 1) % 16;
            end else begin
               slot = (head_slot + fill) % 16;
               fill++;
            end
            ring_time[slot] = stamp;
            for (int c = 0; c < 4; c++) ring_val[slot][c] = v[c];
            res.status = twr_pkg::STAT_APPEND_OK;
         end
         pending.push_back(res);
         return;
      end
      n = points_cfg;
      if (n < 1) n = 1;
      if (n > twr_pkg::MAX_POINTS) n = twr_pkg::MAX_POINTS;
      res.status = twr_pkg::STAT_POINT;
      for (int unsigned i = 0; i < n; i++) begin
         off = (longint'(i) * longint'(horizon)) / n;
         tau = longint'(stamp) - longint'(horizon) + longint'(off);
         for (int c = 0; c < 4; c++) res.point[c] = 0;
         if (fill == 1) begin
            for (int c = 0; c < 4; c++) res.point[c] = value_at(0, c);
         end else if (fill >= 2) begin
            j = 0;
            for (int unsigned k = 1; k + 1 < fill; k++)
               if (stamp_at(k) <= tau) j = k;
            for (int c = 0; c < 4; c++)
               res.point[c] = blend(value_at(j, c), value_at(j + 1, c),
                                    stamp_at(j), stamp_at(j + 1), tau);
         end
         res.last = (i + 1 == n);
         pending.push_back(res);
      end
   endfunction

   task check_result(logic [1:0] status, logic [127:0] data, logic last);
      point_result_type want;
      if (pending.size() == 0) begin
         report($sformatf("unexpected result status %0d", status));
         return;
      end
      want = pending.pop_front();
      if (status !== want.status)
         report($sformatf("status %0d, expected %0d", status, want.status));
      for (int c = 0; c < 4; c++)
         if (data[32*c +: 32] !== want.point[c])
            report($sformatf("channel %0d got %h, expected %h", c,
                             data[32*c +: 32], want.point[c]));
      if (last !== want.last)
         report($sformatf("tlast %b, expected %b", last, want.last));
   endtask
endclass

module tb;
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [159:0]  req_tdata = '0;   // stamp, value_a, value_b, value_c, value_d
   logic          req_tuser = twr_pkg::OP_APPEND;   // opcode
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;        // point_a, point_b, point_c, point_d
   logic [1:0]    rsp_tuser;        // status
   logic          rsp_tlast;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic          csr_index = twr_pkg::REG_WINDOW_LENGTH;
   logic [31:0]   csr_data = '0;

   localparam int QUIET_LIMIT = 40000;

   resample_scoreboard board = new();
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        hold_len = 0;
   int        held = 0;
   int        quiet = 0;
   bit [31:0] newest = 0;

   timestamped_window_resampler uut (.*);

   always #1 clock = ~clock;

   // Receiver: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_len > 0 && held < hold_len) begin
         held <= held + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Observe transfers and run the watchdog
   always @(posedge clock) begin
      logic signed [31:0] v [4];
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            for (int c = 0; c < 4; c++) v[c] = req_tdata[32 + 32*c +: 32];
            board.note_request(req_tuser, req_tdata[31:0], v);
         end
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet <= 0;
         end else if (quiet >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   task send(logic op, bit [31:0] stamp, logic signed [31:0] v [4]);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v[3], v[2], v[1], v[0], stamp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == twr_pkg::OP_APPEND && stamp >= newest) newest = stamp;
   endtask

   task send_append(bit [31:0] stamp, logic signed [31:0] a, logic signed [31:0] b,
                    logic signed [31:0] c, logic signed [31:0] d);
      logic signed [31:0] v [4];
      v[0] = a; v[1] = b; v[2] = c; v[3] = d;
      send(twr_pkg::OP_APPEND, stamp, v);
   endtask

   task send_resample(bit [31:0] stamp);
      logic signed [31:0] v [4];
      for (int c = 0; c < 4; c++) v[c] = $urandom;
      send(twr_pkg::OP_RESAMPLE, stamp, v);
   endtask

   // Drop valid and hold until every expected result has come back
   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task write_csr(logic idx, bit [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3: return $urandom;
         default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   task random_item();
      bit [31:0] t;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         t = newest + $urandom_range(0, 32'h0002_0000);
         send_append(t, pick_value(), pick_value(), pick_value(), pick_value());
      end else if (pick < 68) begin
         t = (newest > 0) ? newest - $urandom_range(1, 32'h0001_0000) : 0;
         send_append(t, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 95) begin
         send_resample(newest + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
      end else begin
         send_resample($urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, single sample, equal stamps, rejection, saturation
      send_resample(32'h0000_0000);
      send_resample(32'hFFFF_FFFF);
      send_append(32'h0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1);
      send_resample(32'h0001_0000);
      send_append(32'h0001_0000, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 5);
      send_resample(32'h0001_8000);
      send_append(32'h0000_8000, 1, 2, 3, 4);
      send_append(32'h0003_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -7);
      send_resample(32'h0008_0000);
      send_resample(32'h0000_0000);
      drain();
      write_csr(twr_pkg::REG_WINDOW_LENGTH, 32'h0000_0000);
      write_csr(twr_pkg::REG_NUM_POINTS, 32'd1);
      send_resample(32'h0002_0000);
      drain();
      write_csr(twr_pkg::REG_NUM_POINTS, 32'd0);
      write_csr(twr_pkg::REG_WINDOW_LENGTH, 32'h0000_0001);
      send_resample(32'h0002_8000);
      drain();
      write_csr(twr_pkg::REG_NUM_POINTS, 32'd127);
      write_csr(twr_pkg::REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
      send_resample(32'h0004_0000);
      drain();
      write_csr(twr_pkg::REG_NUM_POINTS, 32'd64);
      write_csr(twr_pkg::REG_WINDOW_LENGTH, 32'h0008_0000);
      send_resample(32'h0005_0000);
      drain();

      // Random phases, each with its own idling and register setting
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         write_csr(twr_pkg::REG_WINDOW_LENGTH, ($urandom_range(0, 3) == 0) ? $urandom
                                      : $urandom_range(1, 32'h0010_0000));
         write_csr(twr_pkg::REG_NUM_POINTS, (phase == 3) ? 32'd2 : $urandom_range(1, 6));
         for (int i = 0; i < 60; i++) begin
            if (phase == 2 && i == 10) hold_len = 2000;
            if (i == 30) begin
               drain();
               write_csr(twr_pkg::REG_NUM_POINTS, $urandom_range(1, 4));
               write_csr(twr_pkg::REG_WINDOW_LENGTH, $urandom_range(0, 32'h0004_0000));
            end
            random_item();
         end
         drain();
      end

      // Top of the time range
      send_idle_pct = 0;
      stall_pct = 0;
      send_append(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1);
      send_resample(32'hFFFF_FFFF);
      send_append(32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 0);
      send_resample(32'hFFFF_FFFF);
      drain();
      repeat (50) @(posedge clock);

      if (board.pending.size() != 0)
         board.report($sformatf("%0d results never arrived", board.pending.size()));
      if (board.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// File: filelist.f
hdl/twr_pkg.sv
hdl/twr_store.sv
hdl/twr_mul.sv
hdl/twr_div.sv
hdl/timestamped_window_resampler.sv
tb/sv/tb.sv
